>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks one clocked property, off while reset is low.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/pcfd_pkg.sv
`default_nettype none

package pcfd_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 52;
  localparam int ALPHA_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DBAND_W   = 31;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'd32768;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_SRC  = 3'd7;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE  = 4'd0;
  localparam op_t OP_PREP  = 4'd1;
  localparam op_t OP_EM0   = 4'd2;
  localparam op_t OP_EM1   = 4'd3;
  localparam op_t OP_EFIN  = 4'd4;
  localparam op_t OP_DRAW  = 4'd5;
  localparam op_t OP_DM0   = 4'd6;
  localparam op_t OP_DM1   = 4'd7;
  localparam op_t OP_DFIN  = 4'd8;
  localparam op_t OP_GP    = 4'd9;
  localparam op_t OP_GI    = 4'd10;
  localparam op_t OP_GD    = 4'd11;
  localparam op_t OP_DRIVE = 4'd12;

  typedef struct packed {
    logic capture;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic item_run;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> src/pid_controller_filtered_deadband.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  measurement, target, clear_on_change, run
// out      output     out_valid/out_stall drive
// cfg      input      cfg_we             cfg_index, cfg_wdata
//
// Active transaction: PREP, EM0, EM1, EFIN, DRAW, DM0, DM1, DFIN, GP, GI, GD, OUT;
// the order is set by the single shared multiplier doing seven products in sequence.
// Manual transaction: PREP, then OUT. No new accept until the controller is idle.
// rst_n is synchronous; it restores register defaults and clears all loop state.
// The result register lets the next transaction start while out_stall holds the
// previous one; a finished result waits only if the register is still occupied.
`default_nettype none

`include "assert_macros.svh"

module pid_controller_filtered_deadband (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [pcfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pcfd_pkg::DATA_W-1:0]          cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [pcfd_pkg::DATA_W-1:0]   in_measurement,
  input  wire logic signed [pcfd_pkg::DATA_W-1:0]   in_target,
  input  wire logic                                 in_clear_on_change,
  input  wire logic                                 in_run,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [pcfd_pkg::DATA_W-1:0]       out_drive
);

  pcfd_pkg::cmd_t cmd;
  pcfd_pkg::sts_t sts;
  logic           drive_cmd;

  assign drive_cmd = (cmd.op == pcfd_pkg::OP_DRIVE);

  pcfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcfd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_measurement     (in_measurement),
    .in_target          (in_target),
    .in_clear_on_change (in_clear_on_change),
    .in_run             (in_run),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_drive          (out_drive),
    .cmd                (cmd),
    .sts                (sts)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")
  `ASSERT_ALWAYS(a_no_overwrite, !drive_cmd || !(out_valid && out_stall), "pending result overwritten")
  `ASSERT_NEXT(a_drive_sets_valid, drive_cmd, out_valid, "result not presented")

endmodule

`default_nettype wire

>>> src/pcfd_ctrl.sv
`default_nettype none

module pcfd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire pcfd_pkg::sts_t sts,
  output pcfd_pkg::cmd_t     cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_EM0  = 4'd2;
  localparam logic [3:0] ST_EM1  = 4'd3;
  localparam logic [3:0] ST_EFIN = 4'd4;
  localparam logic [3:0] ST_DRAW = 4'd5;
  localparam logic [3:0] ST_DM0  = 4'd6;
  localparam logic [3:0] ST_DM1  = 4'd7;
  localparam logic [3:0] ST_DFIN = 4'd8;
  localparam logic [3:0] ST_GP   = 4'd9;
  localparam logic [3:0] ST_GI   = 4'd10;
  localparam logic [3:0] ST_GD   = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.op      = pcfd_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.op    = pcfd_pkg::OP_PREP;
        state_nxt = sts.item_run ? ST_EM0 : ST_OUT;
      end
      ST_EM0: begin
        cmd.op    = pcfd_pkg::OP_EM0;
        state_nxt = ST_EM1;
      end
      ST_EM1: begin
        cmd.op    = pcfd_pkg::OP_EM1;
        state_nxt = ST_EFIN;
      end
      ST_EFIN: begin
        cmd.op    = pcfd_pkg::OP_EFIN;
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        cmd.op    = pcfd_pkg::OP_DRAW;
        state_nxt = ST_DM0;
      end
      ST_DM0: begin
        cmd.op    = pcfd_pkg::OP_DM0;
        state_nxt = ST_DM1;
      end
      ST_DM1: begin
        cmd.op    = pcfd_pkg::OP_DM1;
        state_nxt = ST_DFIN;
      end
      ST_DFIN: begin
        cmd.op    = pcfd_pkg::OP_DFIN;
        state_nxt = ST_GP;
      end
      ST_GP: begin
        cmd.op    = pcfd_pkg::OP_GP;
        state_nxt = ST_GI;
      end
      ST_GI: begin
        cmd.op    = pcfd_pkg::OP_GI;
        state_nxt = ST_GD;
      end
      ST_GD: begin
        cmd.op    = pcfd_pkg::OP_GD;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          cmd.op    = pcfd_pkg::OP_DRIVE;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/pcfd_dp.sv
`default_nettype none

module pcfd_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [pcfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pcfd_pkg::DATA_W-1:0]           cfg_wdata,
  input  wire logic signed [pcfd_pkg::DATA_W-1:0]    in_measurement,
  input  wire logic signed [pcfd_pkg::DATA_W-1:0]    in_target,
  input  wire logic                                  in_clear_on_change,
  input  wire logic                                  in_run,
  input  wire logic                                  out_stall,
  output logic                                       out_valid,
  output logic signed [pcfd_pkg::DATA_W-1:0]         out_drive,
  input  wire pcfd_pkg::cmd_t                        cmd,
  output pcfd_pkg::sts_t                             sts
);

  localparam int DW = pcfd_pkg::DATA_W;
  localparam int AW = pcfd_pkg::ACC_W;
  localparam int PW = 2 * DW + 1;

  function automatic logic signed [AW-1:0] sx(input logic signed [DW-1:0] v);
    sx = {{(AW-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [AW-1:0] v);
    logic [AW-DW:0] top;
    top = v[AW-1:DW-1];
    if ((top == '0) || (top == '1)) begin
      sat32 = v[DW-1:0];
    end else begin
      sat32 = v[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [DW-1:0] clamp(input logic signed [DW-1:0] v,
                                                 input logic signed [DW-1:0] lo,
                                                 input logic signed [DW-1:0] hi);
    priority if (v > hi) begin
      clamp = hi;
    end else if (v < lo) begin
      clamp = lo;
    end else begin
      clamp = v;
    end
  endfunction

  function automatic logic signed [DW-1:0] band(input logic signed [DW-1:0] v,
                                                input logic [pcfd_pkg::DBAND_W-1:0] db);
    logic [DW-1:0] mag;
    mag  = v[DW-1] ? DW'(-v) : v;
    band = (mag < {1'b0, db}) ? '0 : v;
  endfunction

  // configuration
  logic signed [DW-1:0] gain_p_r, gain_i_r, gain_d_r, lim_lo_r, lim_hi_r;
  logic [pcfd_pkg::DBAND_W-1:0] dband_r;
  logic [DW-1:0] smooth_r;
  logic dsrc_r;

  // controller state
  logic signed [DW-1:0] int_r, perr_r, pmeas_r, pd_r, rec_r, held_r;
  logic signed [DW-1:0] int_nxt, perr_nxt, pmeas_nxt, pd_nxt, rec_nxt, held_nxt;
  logic running_r, running_nxt;

  // working registers
  logic signed [DW-1:0] meas_r, tgt_r, e_r, d_r, drive_r;
  logic signed [DW-1:0] e_nxt, d_nxt, drive_nxt;
  logic clr_r, run_r, valid_r, valid_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;

  logic [pcfd_pkg::ALPHA_W-1:0] a_e, ca_e, a_d, ca_d;
  logic signed [DW-1:0] mul_a;
  logic signed [DW:0]   mul_b;
  logic signed [PW-1:0] prod, prod_sh;
  logic signed [AW-1:0] term_full, term_gain, acc_sh;
  logic signed [DW-1:0] acc_lo, fin_val;

  assign a_e  = (smooth_r[15:0] > pcfd_pkg::ALPHA_ONE) ? pcfd_pkg::ALPHA_ONE : smooth_r[15:0];
  assign a_d  = (smooth_r[31:16] > pcfd_pkg::ALPHA_ONE) ? pcfd_pkg::ALPHA_ONE : smooth_r[31:16];
  assign ca_e = pcfd_pkg::ALPHA_ONE - a_e;
  assign ca_d = pcfd_pkg::ALPHA_ONE - a_d;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      lim_lo_r <= {1'b1, {(DW-1){1'b0}}};
      lim_hi_r <= {1'b0, {(DW-1){1'b1}}};
      dband_r  <= '0;
      smooth_r <= 32'h8000_8000;
      dsrc_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pcfd_pkg::REG_GAIN_P:     gain_p_r <= cfg_wdata;
        pcfd_pkg::REG_GAIN_I:     gain_i_r <= cfg_wdata;
        pcfd_pkg::REG_GAIN_D:     gain_d_r <= cfg_wdata;
        pcfd_pkg::REG_LIMIT_LOW:  lim_lo_r <= cfg_wdata;
        pcfd_pkg::REG_LIMIT_HIGH: lim_hi_r <= cfg_wdata;
        pcfd_pkg::REG_DEAD_BAND:  dband_r  <= cfg_wdata[pcfd_pkg::DBAND_W-1:0];
        pcfd_pkg::REG_SMOOTHING:  smooth_r <= cfg_wdata;
        pcfd_pkg::REG_DERIV_SRC:  dsrc_r   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      pcfd_pkg::OP_EM0: begin
        mul_a = e_r;
        mul_b = $signed({{(DW+1-pcfd_pkg::ALPHA_W){1'b0}}, a_e});
      end
      pcfd_pkg::OP_EM1: begin
        mul_a = perr_r;
        mul_b = $signed({{(DW+1-pcfd_pkg::ALPHA_W){1'b0}}, ca_e});
      end
      pcfd_pkg::OP_DM0: begin
        mul_a = d_r;
        mul_b = $signed({{(DW+1-pcfd_pkg::ALPHA_W){1'b0}}, a_d});
      end
      pcfd_pkg::OP_DM1: begin
        mul_a = pd_r;
        mul_b = $signed({{(DW+1-pcfd_pkg::ALPHA_W){1'b0}}, ca_d});
      end
      pcfd_pkg::OP_GP: begin
        mul_a = gain_p_r;
        mul_b = {e_r[DW-1], e_r};
      end
      pcfd_pkg::OP_GI: begin
        mul_a = gain_i_r;
        mul_b = {int_r[DW-1], int_r};
      end
      pcfd_pkg::OP_GD: begin
        mul_a = gain_d_r;
        mul_b = {d_r[DW-1], d_r};
      end
      default: begin
      end
    endcase
  end

  assign prod      = PW'(mul_a) * PW'(mul_b);
  assign prod_sh   = prod >>> 16;
  assign term_full = prod[AW-1:0];
  assign term_gain = prod_sh[AW-1:0];
  assign acc_sh    = acc_r >>> 15;
  assign acc_lo    = acc_sh[DW-1:0];
  assign fin_val   = clamp(sat32(acc_r), lim_lo_r, lim_hi_r);

  always_comb begin
    int_nxt     = int_r;
    perr_nxt    = perr_r;
    pmeas_nxt   = pmeas_r;
    pd_nxt      = pd_r;
    rec_nxt     = rec_r;
    held_nxt    = held_r;
    running_nxt = running_r;
    e_nxt       = e_r;
    d_nxt       = d_r;
    acc_nxt     = acc_r;
    drive_nxt   = drive_r;
    valid_nxt   = valid_r && out_stall;
    unique case (cmd.op)
      pcfd_pkg::OP_NONE: begin
      end
      pcfd_pkg::OP_PREP: begin
        if (clr_r) begin
          if (rec_r != tgt_r) begin
            int_nxt = '0;
          end
          rec_nxt = tgt_r;
        end
        if (run_r && !running_r) begin
          pmeas_nxt = meas_r;
          int_nxt   = clamp(held_r, lim_lo_r, lim_hi_r);
        end
        running_nxt = run_r;
        e_nxt       = sat32(sx(tgt_r) - sx(meas_r));
      end
      pcfd_pkg::OP_EM0, pcfd_pkg::OP_DM0: begin
        acc_nxt = term_full;
      end
      pcfd_pkg::OP_EM1, pcfd_pkg::OP_DM1: begin
        acc_nxt = acc_r + term_full;
      end
      pcfd_pkg::OP_EFIN: begin
        int_nxt = clamp(sat32(sx(int_r) + sx(acc_lo)), lim_lo_r, lim_hi_r);
        e_nxt   = band(acc_lo, dband_r);
      end
      pcfd_pkg::OP_DRAW: begin
        d_nxt     = band(sat32(dsrc_r ? (sx(pmeas_r) - sx(meas_r)) : (sx(e_r) - sx(perr_r))),
                         dband_r);
        perr_nxt  = e_r;
        pmeas_nxt = meas_r;
      end
      pcfd_pkg::OP_DFIN: begin
        d_nxt  = acc_lo;
        pd_nxt = acc_lo;
      end
      pcfd_pkg::OP_GP: begin
        acc_nxt = term_gain;
      end
      pcfd_pkg::OP_GI, pcfd_pkg::OP_GD: begin
        acc_nxt = acc_r + term_gain;
      end
      pcfd_pkg::OP_DRIVE: begin
        if (run_r) begin
          held_nxt  = fin_val;
          drive_nxt = fin_val;
        end else begin
          drive_nxt = held_r;
        end
        valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r     <= '0;
      perr_r    <= '0;
      pmeas_r   <= '0;
      pd_r      <= '0;
      rec_r     <= '0;
      held_r    <= '0;
      running_r <= 1'b0;
      valid_r   <= 1'b0;
    end else begin
      int_r     <= int_nxt;
      perr_r    <= perr_nxt;
      pmeas_r   <= pmeas_nxt;
      pd_r      <= pd_nxt;
      rec_r     <= rec_nxt;
      held_r    <= held_nxt;
      running_r <= running_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_r <= in_measurement;
      tgt_r  <= in_target;
      clr_r  <= in_clear_on_change;
      run_r  <= in_run;
    end
    e_r     <= e_nxt;
    d_r     <= d_nxt;
    acc_r   <= acc_nxt;
    drive_r <= drive_nxt;
  end

  assign out_valid    = valid_r;
  assign out_drive    = drive_r;
  assign sts.item_run = run_r;
  assign sts.out_busy = valid_r && out_stall;

endmodule

`default_nettype wire

>>> test/pid_controller_filtered_deadband_tb.sv
`timescale 1ns / 1ps

module pid_controller_filtered_deadband_tb;
  import pcfd_pkg::*;

  localparam longint S32_MIN = -(longint'(1) <<< 31);
  localparam longint S32_MAX = (longint'(1) <<< 31) - 1;

  class drive_scoreboard;
    longint gain_p, gain_i, gain_d, lim_lo, lim_hi, dead_zone;
    bit [15:0] err_alpha, der_alpha;
    bit meas_deriv;
    longint integ, last_err, last_meas, last_deriv, last_target, held;
    bit active;
    logic signed [31:0] expected_drives[$];
    int unsigned errors;

    function new();
      gain_p = 0; gain_i = 0; gain_d = 0;
      lim_lo = S32_MIN; lim_hi = S32_MAX;
      dead_zone = 0;
      err_alpha = ALPHA_ONE; der_alpha = ALPHA_ONE;
      meas_deriv = 1'b0;
      integ = 0; last_err = 0; last_meas = 0; last_deriv = 0;
      last_target = 0; held = 0; active = 1'b0;
      errors = 0;
    endfunction

    static function longint sat32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
    endfunction

    // upper limit is tested first; with crossed limits, values not above it get the lower limit
    function longint clamp(longint v);
      if (v > lim_hi) return lim_hi;
      if (v < lim_lo) return lim_lo;
      return v;
    endfunction

    function longint ema(longint x, longint p, bit [15:0] a_raw);
      longint a;
      a = (a_raw > ALPHA_ONE) ? 32768 : longint'(a_raw);
      return (x * a + p * (32768 - a)) >>> 15;
    endfunction

    function longint dband(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      return (m < dead_zone) ? 0 : v;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] v);
      case (idx)
        REG_GAIN_P:     gain_p = longint'(signed'(v));
        REG_GAIN_I:     gain_i = longint'(signed'(v));
        REG_GAIN_D:     gain_d = longint'(signed'(v));
        REG_LIMIT_LOW:  lim_lo = longint'(signed'(v));
        REG_LIMIT_HIGH: lim_hi = longint'(signed'(v));
        REG_DEAD_BAND:  dead_zone = longint'(v[DBAND_W-1:0]);
        REG_SMOOTHING: begin
          err_alpha = v[15:0];
          der_alpha = v[31:16];
        end
        REG_DERIV_SRC:  meas_deriv = v[0];
        default: ;
      endcase
    endfunction

    function void take_sample(longint meas, longint tgt, bit clr, bit run_in);
      longint e, d, y;
      if (clr) begin
        if (last_target != tgt) integ = 0;
        last_target = tgt;
      end
      if (run_in && !active) begin
        last_meas = meas;
        integ = clamp(held);
      end
      active = run_in;
      if (run_in) begin
        e = sat32(tgt - meas);
        e = ema(e, last_err, err_alpha);
        integ = clamp(sat32(integ + e));
        e = dband(e);
        if (meas_deriv) d = sat32(last_meas - meas);
        else d = sat32(e - last_err);
        last_err = e;
        last_meas = meas;
        d = dband(d);
        d = ema(d, last_deriv, der_alpha);
        last_deriv = d;
        y = ((gain_p * e) >>> 16) + ((gain_i * integ) >>> 16) + ((gain_d * d) >>> 16);
        held = clamp(sat32(y));
      end
      expected_drives.push_back(signed'(held[31:0]));
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $time, msg);
      errors++;
    endtask

    task check_drive(logic signed [31:0] got);
      logic signed [31:0] want;
      if (expected_drives.size() == 0) begin
        report($sformatf("unexpected drive %0d", got));
        return;
      end
      want = expected_drives.pop_front();
      if (got !== want) report($sformatf("drive %0d, expected %0d", got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [DATA_W-1:0] in_measurement;
  logic signed [DATA_W-1:0] in_target;
  logic in_clear_on_change;
  logic in_run;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_drive;

  drive_scoreboard sb = new();
  bit hold_request = 1'b0;
  int burst_left = 1;

  pid_controller_filtered_deadband DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_measurement(in_measurement),
    .in_target(in_target),
    .in_clear_on_change(in_clear_on_change),
    .in_run(in_run),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive(out_drive)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_drive(out_drive);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic program_regs(bit [31:0] gp, bit [31:0] gi, bit [31:0] gd, bit [31:0] lo,
                              bit [31:0] hi, bit [31:0] db, bit [31:0] sm, bit [31:0] ds);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_LIMIT_LOW, lo);
    write_reg(REG_LIMIT_HIGH, hi);
    write_reg(REG_DEAD_BAND, db);
    write_reg(REG_SMOOTHING, sm);
    write_reg(REG_DERIV_SRC, ds);
    cfg_we <= 1'b0;
  endtask

  task automatic offer(bit [31:0] meas, bit [31:0] tgt, bit clr, bit run_flag);
    int gap;
    in_valid <= 1'b1;
    in_measurement <= meas;
    in_target <= tgt;
    in_clear_on_change <= clr;
    in_run <= run_flag;
    do @(posedge clk); while (in_stall);
    sb.take_sample(signed'(meas), signed'(tgt), clr, run_flag);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait until every outstanding transaction has come back, or report those that never arrive
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.expected_drives.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_drives.size() > 0) begin
      sb.report($sformatf("%0d drive results never arrived", sb.expected_drives.size()));
      sb.expected_drives.delete();
    end
  endtask

  function automatic bit [31:0] near(bit [31:0] center, int unsigned span);
    longint v;
    v = longint'(signed'(center)) + longint'($urandom_range(0, 2 * span)) - longint'(span);
    v = drive_scoreboard::sat32(v);
    return v[31:0];
  endfunction

  function automatic bit [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return near(32'd0, 32'h30000);
    endcase
  endfunction

  function automatic bit [15:0] rand_alpha();
    case ($urandom_range(0, 4))
      0: return ALPHA_ONE;
      1: return 16'd0;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic random_settings();
    bit [31:0] lo, hi, db, mag;
    mag = $urandom_range(0, 32'h100_0000);
    case ($urandom_range(0, 4))
      0: begin lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; end
      1: begin lo = -mag; hi = $urandom_range(0, 32'h100_0000); end
      2: begin lo = mag; hi = -mag; end
      3: begin lo = $urandom(); hi = $urandom(); end
      default: begin lo = mag; hi = mag; end
    endcase
    case ($urandom_range(0, 4))
      0, 1: db = 32'd0;
      2: db = $urandom_range(0, 32'h8000);
      3: db = $urandom();
      default: db = 32'h7FFF_FFFF;
    endcase
    program_regs(rand_gain(), rand_gain(), rand_gain(), lo, hi, db,
                 {rand_alpha(), rand_alpha()}, $urandom());
  endtask

  initial begin : receiver
    int mode;
    int len;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("FAIL pid_controller_filtered_deadband");
    $finish;
  end

  initial begin : stimulus
    bit [31:0] cur_target;
    int unsigned span;
    int pick;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_measurement <= '0;
    in_target <= '0;
    in_clear_on_change <= 1'b0;
    in_run <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // plain gains, wide limits, no filtering
    program_regs(32'h1_0000, 32'h4000, 32'h8000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'd0, 32'h8000_8000, 32'd0);
    offer(32'd0, 32'd0, 1'b0, 1'b0);
    offer(32'd0, 32'h1_0000, 1'b0, 1'b1);
    offer(32'h8000, 32'h1_0000, 1'b0, 1'b1);
    offer(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1);
    offer(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    offer(32'h1000, 32'h2_0000, 1'b1, 1'b1);
    offer(32'h1000, 32'h2_0000, 1'b1, 1'b1);
    offer(32'h1000, 32'h3_0000, 1'b0, 1'b0);
    offer(32'h2000, 32'h3_0000, 1'b1, 1'b0);
    offer(32'h2000, 32'h3_0000, 1'b0, 1'b1);

    // crossed limits, dead band, alphas above one, measurement derivative
    settle();
    program_regs(32'h2_0000, 32'h1_0000, -32'sh1_0000, 32'h5_0000, -32'sh5_0000,
                 32'h8000, 32'hFFFF_9000, 32'd1);
    offer(32'd0, 32'h4000, 1'b0, 1'b1);
    offer(32'd0, 32'h10_0000, 1'b0, 1'b1);
    offer(32'h20_0000, 32'h10_0000, 1'b0, 1'b1);
    offer(-32'sh30_0000, 32'h10_0000, 1'b0, 1'b1);
    offer(32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1);
    offer(32'd0, 32'd0, 1'b0, 1'b0);

    // extreme gains, widest dead band, derivative alpha zero
    settle();
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h0000_4000, 32'd0);
    offer(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
    offer(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1);
    offer(32'd0, 32'd0, 1'b0, 1'b1);
    offer(32'h1234_5678, 32'hFEDC_BA98, 1'b1, 1'b1);

    // error alpha zero freezes the filtered error
    settle();
    program_regs(32'h1_8000, 32'h2000, 32'h4000, -32'sh100_0000, 32'h100_0000,
                 32'd0, 32'h0000_0000, 32'd1);
    offer(32'h1_0000, 32'h5_0000, 1'b0, 1'b1);
    offer(32'h3_0000, 32'h5_0000, 1'b0, 1'b1);
    offer(32'h6_0000, 32'h5_0000, 1'b0, 1'b1);
    offer(32'h5_0000, 32'h5_0000, 1'b1, 1'b1);

    cur_target = 32'h1_0000;
    for (int phase = 0; phase < 10; phase++) begin
      settle();
      random_settings();
      if (phase == 1) hold_request = 1'b1;
      case ($urandom_range(0, 3))
        0: span = 32'h100;
        1: span = 32'h4000;
        2: span = 32'h4_0000;
        default: span = 32'h100_0000;
      endcase
      for (int n = 0; n < 155; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          offer($urandom(), $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 12) begin
          offer(near(cur_target, span), cur_target, 1'($urandom_range(0, 1)), 1'b0);
        end else if (pick < 20) begin
          case ($urandom_range(0, 3))
            0: cur_target = $urandom();
            1: cur_target = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: cur_target = near(32'd0, 32'h100_0000);
          endcase
          offer(near(cur_target, span), cur_target, $urandom_range(0, 3) != 0, 1'b1);
        end else begin
          offer(near(cur_target, span), cur_target, $urandom_range(0, 7) == 0, 1'b1);
        end
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS pid_controller_filtered_deadband");
    end else begin
      $display("FAIL pid_controller_filtered_deadband");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/pcfd_pkg.sv
src/pcfd_ctrl.sv
src/pcfd_dp.sv
src/pid_controller_filtered_deadband.sv
test/pid_controller_filtered_deadband_tb.sv
